// ----- sv/mv2p_pkg.sv -----
// MAVLink 2 frame parser: shared constants, result type and CRC step.
// No dependencies; used by every module of the parser.
package mv2p_pkg;

	localparam logic [7:0]  START_MARKER  = 8'hFD;
	localparam int          HDR_BYTES     = 9;
	localparam int          HDR_IDX_W     = 4;
	localparam int          CNT_W         = 9;
	localparam logic [8:0]  FIRST_PAYLOAD = 9'd10;
	localparam logic [8:0]  MAX_COUNT     = 9'd266;
	localparam logic [15:0] CRC_INIT      = 16'hFFFF;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [7:0]  byte_index;
		logic [7:0]  hdr_len;
		logic [7:0]  flags_incompat;
		logic [7:0]  flags_compat;
		logic [7:0]  sequence_res;
		logic [7:0]  system_id;
		logic [7:0]  component_id;
		logic [23:0] message_id;
		logic [15:0] received_checksum;
		logic [15:0] computed_crc;
	} res_t;

	// CRC-16/MCRF4XX, one byte
	function automatic logic [15:0] crc_step(input logic [7:0] b, input logic [15:0] crc);
		logic [7:0] t;
		t = b ^ crc[7:0];
		t = t ^ {t[3:0], 4'h0};
		return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b0, t, 3'b0} ^ {12'h000, t[7:4]};
	endfunction

endpackage

// ----- sv/mv2p_if.sv -----
// Handshake channels of the MAVLink 2 frame parser: received bytes and results.
// No dependencies.
interface mv2p_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, rx_byte, input ready);
	modport sink(input valid, rx_byte, output ready);
endinterface

interface mv2p_res_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  data_byte;
	logic [7:0]  byte_index;
	logic [7:0]  hdr_len;
	logic [7:0]  flags_incompat;
	logic [7:0]  flags_compat;
	logic [7:0]  sequence_res;
	logic [7:0]  system_id;
	logic [7:0]  component_id;
	logic [23:0] message_id;
	logic [15:0] received_checksum;
	logic [15:0] computed_crc;

	modport source(output valid, kind, data_byte, byte_index, hdr_len, flags_incompat,
		flags_compat, sequence_res, system_id, component_id, message_id,
		received_checksum, computed_crc, input ready);
	modport sink(input valid, kind, data_byte, byte_index, hdr_len, flags_incompat,
		flags_compat, sequence_res, system_id, component_id, message_id,
		received_checksum, computed_crc, output ready);
endinterface

// ----- sv/mv2p_parse.sv -----
// Frame state of the parser: byte counter, header bytes, trailer and running CRC.
// Depends on mv2p_pkg.
module mv2p_parse import mv2p_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       go,
	input  logic [7:0] b,
	output logic       res_valid,
	output res_t       res
);

	logic [CNT_W-1:0]     cnt_q;
	logic [7:0]           hdr_q [HDR_BYTES];
	logic [7:0]           chk_lo_q;
	logic [15:0]          crc_q;
	logic [CNT_W-1:0]     pos;
	logic [CNT_W-1:0]     len9;
	logic [HDR_IDX_W-1:0] hdr_idx;
	logic                 idle, in_hdr, in_pay, chk_lo, chk_hi;
	logic [15:0]          crc_nxt;

	assign pos     = cnt_q - FIRST_PAYLOAD;
	assign len9    = {1'b0, hdr_q[0]};
	assign hdr_idx = HDR_IDX_W'(cnt_q - 9'd1);
	assign idle    = (cnt_q == '0);
	assign in_hdr  = !idle && (cnt_q <= CNT_W'(HDR_BYTES));
	assign in_pay  = !idle && !in_hdr && (pos < len9);
	assign chk_lo  = !idle && !in_hdr && (pos == len9);
	assign chk_hi  = !idle && !in_hdr && (pos > len9);
	assign crc_nxt = crc_step(b, crc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			crc_q <= CRC_INIT;
		end else if (go) begin
			if (idle) begin
				if (b == START_MARKER) begin
					cnt_q <= CNT_W'(1);
					crc_q <= CRC_INIT;
				end
			end else if (chk_hi) begin
				cnt_q <= '0;
				crc_q <= CRC_INIT;
			end else begin
				cnt_q <= cnt_q + 9'd1;
				if (in_hdr || in_pay)
					crc_q <= crc_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && in_hdr) begin
			for (int i = 0; i < HDR_BYTES; i++)
				if (hdr_idx == HDR_IDX_W'(i))
					hdr_q[i] <= b;
		end
		if (go && chk_lo)
			chk_lo_q <= b;
	end

	assign res_valid = in_pay || chk_hi;

	always_comb begin
		res = '0;
		if (in_pay) begin
			res.kind       = KIND_PAYLOAD;
			res.data_byte  = b;
			res.byte_index = pos[7:0];
		end else begin
			res.kind              = KIND_END;
			res.hdr_len           = hdr_q[0];
			res.flags_incompat    = hdr_q[1];
			res.flags_compat      = hdr_q[2];
			res.sequence_res      = hdr_q[3];
			res.system_id         = hdr_q[4];
			res.component_id      = hdr_q[5];
			res.message_id        = {hdr_q[8], hdr_q[7], hdr_q[6]};
			res.received_checksum = {b, chk_lo_q};
			res.computed_crc      = crc_q;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_COUNT) else $error("frame counter past longest frame");
	a_idle_crc: assert property (@(posedge clk) disable iff (!arst_n)
		idle |-> crc_q == CRC_INIT) else $error("crc not at init while idle");
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go && chk_hi |=> idle) else $error("no return to idle after frame end");
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_pay && chk_hi) && !(in_pay && chk_lo)) else $error("overlapping frame phases");

endmodule

// ----- sv/mv2p_out_stage.sv -----
// Result register of the parser; holds a word until the sink takes it.
// Depends on mv2p_pkg and mv2p_res_if.
module mv2p_out_stage import mv2p_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  res_t         res_in,
	output logic         can_take,
	mv2p_res_if.source   res
);

	logic valid_q;
	res_t res_q;

	assign can_take = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_take) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && load)
			res_q <= res_in;
	end

	assign res.valid             = valid_q;
	assign res.kind              = res_q.kind;
	assign res.data_byte         = res_q.data_byte;
	assign res.byte_index        = res_q.byte_index;
	assign res.hdr_len           = res_q.hdr_len;
	assign res.flags_incompat    = res_q.flags_incompat;
	assign res.flags_compat      = res_q.flags_compat;
	assign res.sequence_res      = res_q.sequence_res;
	assign res.system_id         = res_q.system_id;
	assign res.component_id      = res_q.component_id;
	assign res.message_id        = res_q.message_id;
	assign res.received_checksum = res_q.received_checksum;
	assign res.computed_crc      = res_q.computed_crc;

endmodule

// ----- sv/mavlink2_frame_parser.sv -----
// MAVLink 2 frame parser top level: input byte register, frame state, result register.
// Depends on mv2p_pkg, mv2p_if, mv2p_parse and mv2p_out_stage.
// Takes one received byte per clock cycle while the sink keeps up, and offers the result
// word from the result register: the byte is held in the input register, the frame
// counter and CRC-16/MCRF4XX update are worked out from it and the word lands in the
// result register. While a word waits there with the sink not ready, every byte stalls. Bytes
// outside a frame are dropped until the 0xFD start marker; each payload byte yields
// a payload word, the second checksum byte yields the frame-end word with header,
// received checksum and computed CRC (not compared). No resync within a frame.
module mavlink2_frame_parser import mv2p_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	mv2p_rx_if.sink    rx,
	mv2p_res_if.source res
);

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       can_take;
	logic       go;
	logic       res_valid;
	res_t       res_c;

	assign go       = v_s1 && can_take;
	assign rx.ready = !v_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rx.ready) begin
			v_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready)
			byte_s1 <= rx.rx_byte;
	end

	mv2p_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.b         (byte_s1),
		.res_valid (res_valid),
		.res       (res_c)
	);

	mv2p_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (go && res_valid),
		.res_in   (res_c),
		.can_take (can_take),
		.res      (res)
	);

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !go |=> v_s1 && $stable(byte_s1)) else $error("stalled input word lost");
	a_no_load_full: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> can_take) else $error("advance into full result register");
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> rx.ready) else $error("empty input register not ready");

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for mavlink2_frame_parser: byte driver, result monitor, frame predictor.
// Depends on mv2p_pkg, mv2p_if and the parser RTL.
module testbench import mv2p_pkg::*;;

	localparam int N_ITEMS    = 1300;
	localparam int QUIET_TAIL = 150;

	logic clk = 1'b0;
	logic arst_n;

	mv2p_rx_if  rx_ch();
	mv2p_res_if res_ch();

	mavlink2_frame_parser u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	logic [7:0] tx_bytes[$];
	res_t       expected_words[$];

	// predictor state
	logic [8:0]  frame_pos;
	logic [7:0]  hdr [HDR_BYTES];
	logic [7:0]  cks_lo;
	logic [15:0] crc_acc;

	int   err_count = 0;
	int   n_items   = 0;
	int   n_frames  = 0;
	int   n_payload = 0;
	int   n_ends    = 0;
	int   in_gap    = 0;
	int   out_hold  = 0;
	logic quiet;

	task automatic report(input string what, input logic [23:0] got, input logic [23:0] want);
		err_count++;
		if (err_count <= 40)
			$display("mismatch %s: got %0h want %0h", what, got, want);
	endtask

	// CRC-16/MCRF4XX, bitwise with the reflected polynomial
	function automatic logic [15:0] mcrf_update(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] c;
		c = acc ^ {8'h00, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
		return c;
	endfunction

	task automatic parse_byte(input logic [7:0] b);
		res_t       w;
		logic [8:0] pos;
		w = '0;
		if (frame_pos == 9'd0) begin
			if (b == START_MARKER) begin
				frame_pos = 9'd1;
				crc_acc   = CRC_INIT;
			end
		end else if (frame_pos <= HDR_BYTES) begin
			hdr[frame_pos - 9'd1] = b;
			crc_acc   = mcrf_update(crc_acc, b);
			frame_pos = frame_pos + 9'd1;
		end else begin
			pos = frame_pos - FIRST_PAYLOAD;
			if (pos < {1'b0, hdr[0]}) begin
				crc_acc      = mcrf_update(crc_acc, b);
				frame_pos    = frame_pos + 9'd1;
				w.kind       = KIND_PAYLOAD;
				w.data_byte  = b;
				w.byte_index = pos[7:0];
				expected_words.push_back(w);
			end else if (pos == {1'b0, hdr[0]}) begin
				cks_lo    = b;
				frame_pos = frame_pos + 9'd1;
			end else begin
				w.kind              = KIND_END;
				w.hdr_len           = hdr[0];
				w.flags_incompat    = hdr[1];
				w.flags_compat      = hdr[2];
				w.sequence_res      = hdr[3];
				w.system_id         = hdr[4];
				w.component_id      = hdr[5];
				w.message_id        = {hdr[8], hdr[7], hdr[6]};
				w.received_checksum = {b, cks_lo};
				w.computed_crc      = crc_acc;
				expected_words.push_back(w);
				frame_pos = 9'd0;
				crc_acc   = CRC_INIT;
			end
		end
	endtask

	// fixed fill: header bytes hfill, payload pfill, checksum {pfill, hfill}
	task automatic add_frame(input logic [7:0] len, input logic [7:0] hfill,
			input logic [7:0] pfill, input bit rnd);
		logic [7:0] b;
		tx_bytes.push_back(START_MARKER);
		tx_bytes.push_back(len);
		for (int i = 1; i <= int'(len) + 10; i++) begin
			if (rnd)
				b = ($urandom_range(0, 15) == 0) ? START_MARKER : 8'($urandom);
			else if (i <= 8)
				b = hfill;
			else if (i <= int'(len) + 8)
				b = pfill;
			else if (i == int'(len) + 9)
				b = hfill;
			else
				b = pfill;
			tx_bytes.push_back(b);
		end
		n_items += int'(len) + 12;
		n_frames++;
	endtask

	task automatic add_noise(input int n);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			b = 8'($urandom_range(0, 254));
			if (b == START_MARKER)
				b = 8'hFF;
			tx_bytes.push_back(b);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : byte_driver
		if (!arst_n) begin
			rx_ch.valid   <= 1'b0;
			rx_ch.rx_byte <= '0;
			quiet         <= 1'b0;
			in_gap = 0;
		end else begin
			if (rx_ch.valid && rx_ch.ready)
				parse_byte(rx_ch.rx_byte);
			quiet <= (tx_bytes.size() < QUIET_TAIL);
			if (!rx_ch.valid || rx_ch.ready) begin
				if (in_gap > 0) begin
					in_gap--;
					rx_ch.valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 15) == 0) begin
					in_gap = $urandom_range(1, 14) - 1;
					rx_ch.valid <= 1'b0;
				end else if (tx_bytes.size() != 0) begin
					rx_ch.valid   <= 1'b1;
					rx_ch.rx_byte <= tx_bytes.pop_front();
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : res_monitor
		res_t got;
		res_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			out_hold = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				got = {res_ch.kind, res_ch.data_byte, res_ch.byte_index, res_ch.hdr_len,
					res_ch.flags_incompat, res_ch.flags_compat, res_ch.sequence_res,
					res_ch.system_id, res_ch.component_id, res_ch.message_id,
					res_ch.received_checksum, res_ch.computed_crc};
				if (expected_words.size() == 0) begin
					report("unexpected word, kind", 24'(got.kind), 24'd0);
				end else begin
					want = expected_words.pop_front();
					if (want.kind == KIND_END)
						n_ends++;
					else
						n_payload++;
					if (got.kind !== want.kind)
						report("kind", 24'(got.kind), 24'(want.kind));
					if (got.data_byte !== want.data_byte)
						report("data_byte", 24'(got.data_byte), 24'(want.data_byte));
					if (got.byte_index !== want.byte_index)
						report("byte_index", 24'(got.byte_index), 24'(want.byte_index));
					if (got.hdr_len !== want.hdr_len)
						report("hdr_len", 24'(got.hdr_len), 24'(want.hdr_len));
					if (got.flags_incompat !== want.flags_incompat)
						report("flags_incompat", 24'(got.flags_incompat),
							24'(want.flags_incompat));
					if (got.flags_compat !== want.flags_compat)
						report("flags_compat", 24'(got.flags_compat), 24'(want.flags_compat));
					if (got.sequence_res !== want.sequence_res)
						report("sequence_res", 24'(got.sequence_res), 24'(want.sequence_res));
					if (got.system_id !== want.system_id)
						report("system_id", 24'(got.system_id), 24'(want.system_id));
					if (got.component_id !== want.component_id)
						report("component_id", 24'(got.component_id), 24'(want.component_id));
					if (got.message_id !== want.message_id)
						report("message_id", got.message_id, want.message_id);
					if (got.received_checksum !== want.received_checksum)
						report("received_checksum", 24'(got.received_checksum),
							24'(want.received_checksum));
					if (got.computed_crc !== want.computed_crc)
						report("computed_crc", 24'(got.computed_crc), 24'(want.computed_crc));
				end
			end
			if (out_hold > 0) begin
				out_hold--;
				res_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 15) == 0) begin
				out_hold = $urandom_range(1, 14) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : run_ctrl
		logic [7:0] len;
		int         r;
		bit         first_big;
		arst_n        = 1'b0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		res_ch.ready  = 1'b0;
		quiet         = 1'b0;
		frame_pos     = 9'd0;
		cks_lo        = '0;
		crc_acc       = CRC_INIT;
		for (int i = 0; i < HDR_BYTES; i++)
			hdr[i] = '0;

		// idle bytes near the marker are dropped
		tx_bytes.push_back(8'h00);
		tx_bytes.push_back(8'hFF);
		tx_bytes.push_back(8'hFC);
		tx_bytes.push_back(8'hFE);
		// empty payload, all-ones header
		add_frame(8'd0, 8'hFF, 8'h00, 1'b0);
		// marker value inside header, payload and checksum
		add_frame(8'd1, START_MARKER, START_MARKER, 1'b0);

		first_big = 1'b1;
		while (n_items < N_ITEMS) begin
			if ($urandom_range(0, 3) == 0)
				add_noise($urandom_range(1, 5));
			r = $urandom_range(0, 99);
			if (first_big || r < 2)
				len = 8'd255;
			else if (r < 75)
				len = 8'($urandom_range(0, 12));
			else
				len = 8'($urandom_range(13, 80));
			first_big = 1'b0;
			add_frame(len, 8'h00, 8'h00, 1'b1);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (tx_bytes.size() != 0 || rx_ch.valid || expected_words.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (expected_words.size() != 0)
			report("words left over", 24'(expected_words.size()), 24'd0);

		$display("run covered %0d frames in %0d frame bytes", n_frames, n_items);
		$display("checked %0d payload words and %0d frame-end words", n_payload, n_ends);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : watchdog
		#4000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
